@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker RTL.
// Each macro takes a label, a clock, a disable condition, an antecedent and a consequent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define LCTD_ASSERT_SAME(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("lctd assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define LCTD_ASSERT_NEXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("lctd assertion failed");

`else

`define LCTD_ASSERT_SAME(label, clk, dis, ante, cons)
`define LCTD_ASSERT_NEXT(label, clk, dis, ante, cons)

`endif

`endif

@@ rtl/lctd_pkg.sv @@
package lctd_pkg;

  // Byte codes the lexer reacts to.
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_SEMI      = 8'h3B;
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_QMARK     = 8'h3F;

  // Saturation point of the per-line count and reset value of the limit.
  localparam logic [7:0] COUNT_MAX        = 8'hFF;
  localparam logic [7:0] MAX_TOKENS_RESET = 8'd3;

  // Lexical state held across the bytes of one line.
  typedef struct packed {
    logic       in_string;
    logic       in_char_literal;
    logic       in_block_comment;
    logic       in_line_comment;
    logic       slash_pending;
    logic       star_pending;
    logic       escape_pending;
    logic [7:0] line_tokens;
  } lex_state_t;

  localparam lex_state_t LEX_CLEAR = '0;

  // What the lexer reports for one processed byte.
  typedef struct packed {
    logic       done;
    logic [7:0] count;
    logic       last;
  } lex_result_t;

endpackage

@@ rtl/line_control_token_density_check.sv @@
// Control-token density checker for C source text.
// The input channel takes one byte of text per beat (in_char_in) with
// in_end_of_file marking the final byte. A beat is accepted at a rising edge
// with in_valid high and in_stall low. Semicolons, open braces and question
// marks outside strings, character literals and comments are counted per line.
// A newline, or the byte marked end of file, closes the line and yields one
// result beat: the count (saturating at 255), a flag when the count exceeds
// max_tokens, and a flag for the final line. Other bytes yield no result.
// The byte passes an input register and is lexed into the result register,
// from which the result is offered on out_valid. One byte per cycle is taken
// while out_stall is low; the lexer state update is the only loop.
// When out_stall holds a result, the input register still fills, and in_stall
// rises only once that register is also occupied. The user writes max_tokens
// via cfg_wr_en/cfg_wr_data only while the block is idle, not enforced by it;
// max_tokens resets to 3. Synchronous active-low reset empties both registers
// and clears all lexical state; no clearing pass is needed.
module line_control_token_density_check
  import lctd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_in,
  input  logic       in_end_of_file,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_token_count,
  output logic       out_too_dense,
  output logic       out_last_line,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

`include "assert_macros.svh"

  logic        s1_valid_r;
  logic [7:0]  s1_char_r;
  logic        s1_eof_r;
  logic        out_valid_r;
  logic [7:0]  out_count_r;
  logic        out_dense_r;
  logic        out_last_r;
  logic [7:0]  max_tokens_r;
  logic        adv;
  logic        in_take;
  lex_result_t lex_res;

  // The held byte moves on when the result register is free or being drained.
  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_tokens_r <= MAX_TOKENS_RESET;
    end else if (cfg_wr_en) begin
      max_tokens_r <= cfg_wr_data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_char_r <= in_char_in;
      s1_eof_r  <= in_end_of_file;
    end
  end

  lctd_lexer u_lexer (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (adv),
    .char_in     (s1_char_r),
    .end_of_file (s1_eof_r),
    .res         (lex_res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && lex_res.done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && lex_res.done) begin
      out_count_r <= lex_res.count;
      out_dense_r <= (lex_res.count > max_tokens_r);
      out_last_r  <= lex_res.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_token_count = out_count_r;
  assign out_too_dense   = out_dense_r;
  assign out_last_line   = out_last_r;

  // A byte taken while the input register is full must see that byte move on.
  `LCTD_ASSERT_SAME(a_no_overwrite, clk, !rst_n, in_take && s1_valid_r, adv)
  // A stalled result is never dropped.
  `LCTD_ASSERT_NEXT(a_stalled_kept, clk, !rst_n, out_valid && out_stall, out_valid)
  // Every newline closes a line.
  `LCTD_ASSERT_SAME(a_newline_done, clk, !rst_n, adv && (s1_char_r == CH_NEWLINE),
                    lex_res.done)
  // Reset leaves both registers empty.
  `LCTD_ASSERT_NEXT(a_reset_empty, clk, 1'b0, !rst_n, !out_valid_r && !s1_valid_r)

endmodule

@@ rtl/lctd_lexer.sv @@
module lctd_lexer
  import lctd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        take,
  input  logic [7:0]  char_in,
  input  logic        end_of_file,
  output lex_result_t res
);

  lex_state_t st_r;
  lex_state_t st_nxt;
  lex_state_t upd;
  logic       cont;
  logic       is_token;

  // Advance the lexical state by one byte of text.
  always_comb begin
    upd      = st_r;
    cont     = 1'b0;
    is_token = (char_in == CH_SEMI) || (char_in == CH_LBRACE) || (char_in == CH_QMARK);
    if (!st_r.in_line_comment) begin
      if (st_r.escape_pending) begin
        upd.escape_pending = 1'b0;
      end else if (st_r.in_block_comment) begin
        if (st_r.star_pending && (char_in == CH_SLASH)) begin
          upd.in_block_comment = 1'b0;
          upd.star_pending     = 1'b0;
        end else begin
          upd.star_pending = (char_in == CH_STAR);
        end
      end else begin
        cont = 1'b1;
        // A waiting slash either opens a comment or is simply dropped.
        if (st_r.slash_pending) begin
          upd.slash_pending = 1'b0;
          if (char_in == CH_STAR) begin
            upd.in_block_comment = 1'b1;
            upd.star_pending     = 1'b0;
            cont                 = 1'b0;
          end else if (char_in == CH_SLASH) begin
            upd.in_line_comment = 1'b1;
            cont                = 1'b0;
          end
        end
        if (cont) begin
          if (!st_r.in_string && !st_r.in_char_literal && (char_in == CH_SLASH)) begin
            upd.slash_pending = 1'b1;
          end else if (char_in == CH_BACKSLASH) begin
            upd.escape_pending = 1'b1;
          end else begin
            if (!st_r.in_char_literal && (char_in == CH_DQUOTE)) begin
              upd.in_string = !st_r.in_string;
            end else if (!st_r.in_string && (char_in == CH_SQUOTE)) begin
              upd.in_char_literal = !st_r.in_char_literal;
            end
            if (!upd.in_string && !upd.in_char_literal && is_token &&
                (st_r.line_tokens != COUNT_MAX)) begin
              upd.line_tokens = st_r.line_tokens + 8'd1;
            end
          end
        end
      end
    end
  end

  // A newline closes the line untouched; any other byte is lexed first.
  always_comb begin
    if (char_in == CH_NEWLINE) begin
      res.done  = 1'b1;
      res.count = st_r.line_tokens;
    end else begin
      res.done  = end_of_file;
      res.count = upd.line_tokens;
    end
    res.last = end_of_file;
    if (res.done) begin
      st_nxt = LEX_CLEAR;
    end else begin
      st_nxt = upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= LEX_CLEAR;
    end else if (take) begin
      st_r <= st_nxt;
    end
  end

endmodule
